/* rtl/core/biquad_iir_filter_unit_assert.svh */
`ifndef BIQUAD_IIR_FILTER_UNIT_ASSERT_SVH
`define BIQUAD_IIR_FILTER_UNIT_ASSERT_SVH

// Concurrent check that is switched off while reset is held.
`define BIQUAD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent check that also covers the reset cycles.
`define BIQUAD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* rtl/core/biquad_pkg.sv */
package biquad_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 28;
    localparam int COEF_W             = 32;
    localparam int ORDER_W            = 2;
    localparam int CFG_IDX_W          = 3;

    localparam logic [ORDER_W-1:0] ORDER_FEED   = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_FIRST  = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_SECOND = 2'd2;

    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_A2    = 3'd5;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [COEF_W-1:0]  coef_b0;
        logic [COEF_W-1:0]  coef_b1;
        logic [COEF_W-1:0]  coef_b2;
        logic [COEF_W-1:0]  coef_a1;
        logic [COEF_W-1:0]  coef_a2;
    } t_cfg;

endpackage

/* rtl/core/biquad_mac.sv */
module biquad_mac #(
    parameter int SAMPLE_WIDTH   = biquad_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = biquad_pkg::COEF_FRAC_BITS_DEF
) (
    input  biquad_pkg::t_cfg          i_cfg,
    input  logic                      i_mode,
    input  logic [SAMPLE_WIDTH-1:0]   i_sample,
    input  logic [SAMPLE_WIDTH-1:0]   i_x1,
    input  logic [SAMPLE_WIDTH-1:0]   i_x2,
    input  logic [SAMPLE_WIDTH-1:0]   i_y1,
    input  logic [SAMPLE_WIDTH-1:0]   i_y2,
    output logic [SAMPLE_WIDTH-1:0]   o_sample,
    output logic                      o_saturated,
    output logic [SAMPLE_WIDTH-1:0]   o_x1,
    output logic [SAMPLE_WIDTH-1:0]   o_x2,
    output logic [SAMPLE_WIDTH-1:0]   o_y1,
    output logic [SAMPLE_WIDTH-1:0]   o_y2
);

    localparam int PROD_W = biquad_pkg::COEF_W + SAMPLE_WIDTH;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] S_MAX = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - ACC_W'(1);

    logic signed [PROD_W-1:0] p_b0;
    logic signed [PROD_W-1:0] p_b1;
    logic signed [PROD_W-1:0] p_b2;
    logic signed [PROD_W-1:0] p_a1;
    logic signed [PROD_W-1:0] p_a2;
    logic signed [ACC_W-1:0]  acc_first;
    logic signed [ACC_W-1:0]  acc_second;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  scaled;
    logic [SAMPLE_WIDTH-1:0]  y_clip;
    logic                     y_sat;
    logic                     is_second;

    assign p_b0 = $signed(i_cfg.coef_b0) * $signed(i_sample);
    assign p_b1 = $signed(i_cfg.coef_b1) * $signed(i_x1);
    assign p_b2 = $signed(i_cfg.coef_b2) * $signed(i_x2);
    assign p_a1 = $signed(i_cfg.coef_a1) * $signed(i_y1);
    assign p_a2 = $signed(i_cfg.coef_a2) * $signed(i_y2);

    assign is_second  = (i_cfg.order == biquad_pkg::ORDER_SECOND);
    assign acc_first  = ACC_W'(p_b0) + ACC_W'(p_b1) - ACC_W'(p_a1) + ROUND_HALF;
    assign acc_second = ACC_W'(p_b2) - ACC_W'(p_a2);
    assign acc        = is_second ? acc_first + acc_second : acc_first;
    assign scaled     = acc >>> COEF_FRAC_BITS;

    always_comb begin
        if (scaled > S_MAX) begin
            y_clip = S_MAX[SAMPLE_WIDTH-1:0];
            y_sat  = 1'b1;
        end else if (scaled < S_MIN) begin
            y_clip = S_MIN[SAMPLE_WIDTH-1:0];
            y_sat  = 1'b1;
        end else begin
            y_clip = scaled[SAMPLE_WIDTH-1:0];
            y_sat  = 1'b0;
        end
    end

    always_comb begin
        o_sample    = i_sample;
        o_saturated = 1'b0;
        o_x1        = i_x1;
        o_x2        = i_x2;
        o_y1        = i_y1;
        o_y2        = i_y2;
        if (i_mode == biquad_pkg::MODE_CLEAR) begin
            o_sample = '0;
            o_x1     = '0;
            o_x2     = '0;
            o_y1     = '0;
            o_y2     = '0;
        end else if (i_cfg.order inside {biquad_pkg::ORDER_FIRST, biquad_pkg::ORDER_SECOND}) begin
            o_sample    = y_clip;
            o_saturated = y_sat;
            o_x1        = i_sample;
            o_y1        = y_clip;
            if (is_second) begin
                o_x2 = i_x1;
                o_y2 = i_y1;
            end
        end
    end

endmodule

/* rtl/core/biquad_iir_filter_unit.sv */
// Direct form I biquad filter for a stream of signed samples.
// Input channel s_axis: tdata carries sample_in, tuser carries mode
// (0 filters the sample, 1 clears the history and yields zero).
// Output channel m_axis: tdata carries sample_out, tuser carries saturated.
// Coefficients and the filter order are written through i_cfg_wr_en,
// i_cfg_index and i_cfg_wdata while the stream is idle.
// Each accepted transfer yields exactly one result transfer. With the
// output free, the sample is captured by the input register and its
// result by the output register. While the receiver takes results,
// one sample is taken per cycle: the five products, their sum,
// rounding and clipping are computed combinationally between the
// input register and the output register.
// A synchronous reset clears both histories, empties the pipeline and
// restores the coefficient registers to feed-through with b0 of one.
// When the receiver stalls, the output register holds its result and the
// input register holds the next sample; s_axis_tready drops only while
// both are full.
module biquad_iir_filter_unit #(
    parameter int   SAMPLE_WIDTH   = biquad_pkg::SAMPLE_WIDTH_DEF,
    parameter int   COEF_FRAC_BITS = biquad_pkg::COEF_FRAC_BITS_DEF,
    localparam int  TDATA_W        = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [biquad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [biquad_pkg::COEF_W-1:0]     i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [TDATA_W-1:0]                s_axis_tdata,  // sample_in
    input  logic                              s_axis_tuser,  // mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [TDATA_W-1:0]                m_axis_tdata,  // sample_out
    output logic                              m_axis_tuser   // saturated
);

    localparam logic [biquad_pkg::COEF_W-1:0] B0_RESET =
        biquad_pkg::COEF_W'(1) << COEF_FRAC_BITS;

    biquad_pkg::t_cfg          r_cfg;
    logic                      r_s1_valid;
    logic                      r_s1_mode;
    logic [SAMPLE_WIDTH-1:0]   r_s1_sample;
    logic                      r_out_valid;
    logic [SAMPLE_WIDTH-1:0]   r_out_sample;
    logic                      r_out_sat;
    logic [SAMPLE_WIDTH-1:0]   r_x1;
    logic [SAMPLE_WIDTH-1:0]   r_x2;
    logic [SAMPLE_WIDTH-1:0]   r_y1;
    logic [SAMPLE_WIDTH-1:0]   r_y2;
    logic [SAMPLE_WIDTH-1:0]   n_out_sample;
    logic                      n_out_sat;
    logic [SAMPLE_WIDTH-1:0]   n_x1;
    logic [SAMPLE_WIDTH-1:0]   n_x2;
    logic [SAMPLE_WIDTH-1:0]   n_y1;
    logic [SAMPLE_WIDTH-1:0]   n_y2;
    logic                      in_fire;
    logic                      s1_advance;

    assign s1_advance    = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_sample);
    assign m_axis_tuser  = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.order   <= biquad_pkg::ORDER_FEED;
            r_cfg.coef_b0 <= B0_RESET;
            r_cfg.coef_b1 <= '0;
            r_cfg.coef_b2 <= '0;
            r_cfg.coef_a1 <= '0;
            r_cfg.coef_a2 <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                biquad_pkg::CFG_ORDER: r_cfg.order   <= i_cfg_wdata[biquad_pkg::ORDER_W-1:0];
                biquad_pkg::CFG_B0:    r_cfg.coef_b0 <= i_cfg_wdata;
                biquad_pkg::CFG_B1:    r_cfg.coef_b1 <= i_cfg_wdata;
                biquad_pkg::CFG_B2:    r_cfg.coef_b2 <= i_cfg_wdata;
                biquad_pkg::CFG_A1:    r_cfg.coef_a1 <= i_cfg_wdata;
                biquad_pkg::CFG_A2:    r_cfg.coef_a2 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_mode   <= s_axis_tuser;
            r_s1_sample <= s_axis_tdata[SAMPLE_WIDTH-1:0];
        end
    end

    biquad_mac #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_cfg       (r_cfg),
        .i_mode      (r_s1_mode),
        .i_sample    (r_s1_sample),
        .i_x1        (r_x1),
        .i_x2        (r_x2),
        .i_y1        (r_y1),
        .i_y2        (r_y2),
        .o_sample    (n_out_sample),
        .o_saturated (n_out_sat),
        .o_x1        (n_x1),
        .o_x2        (n_x2),
        .o_y1        (n_y1),
        .o_y2        (n_y2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (s1_advance) begin
            r_x1 <= n_x1;
            r_x2 <= n_x2;
            r_y1 <= n_y1;
            r_y2 <= n_y2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_sample <= n_out_sample;
            r_out_sat    <= n_out_sat;
        end
    end

endmodule

/* rtl/core/biquad_checker.sv */
`include "biquad_iir_filter_unit_assert.svh"

module biquad_checker #(
    parameter int   SAMPLE_WIDTH = biquad_pkg::SAMPLE_WIDTH_DEF,
    localparam int  TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [TDATA_W-1:0]   m_axis_tdata,
    input logic                 m_axis_tuser
);

    localparam logic [SAMPLE_WIDTH-1:0] SAT_HI = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAT_LO = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    `BIQUAD_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !m_axis_tvalid,
        "output valid right after reset")

    `BIQUAD_ASSERT(a_stall_holds, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser),
        "stalled result changed")

    `BIQUAD_ASSERT(a_backpressure_only_when_full, i_clk, i_rst_n,
        !s_axis_tready |-> m_axis_tvalid,
        "input stalled while output is empty")

    `BIQUAD_ASSERT(a_sat_at_limit, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[SAMPLE_WIDTH-1:0] == SAT_HI)
            || (m_axis_tdata[SAMPLE_WIDTH-1:0] == SAT_LO),
        "saturated result is not at a range limit")

    `BIQUAD_ASSERT(a_input_unused_reset, i_clk, i_rst_n,
        $rose(i_rst_n) |-> s_axis_tready,
        "input not ready after reset")

endmodule

bind biquad_iir_filter_unit biquad_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_biquad_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* bench/biquad_iir_filter_unit_tb.sv */
`timescale 1ns / 100ps

module biquad_iir_filter_unit_tb;

    localparam int SW = 24;
    localparam int TW = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [biquad_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [biquad_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam longint SMAX = 64'sd8388607;
    localparam longint SMIN = -64'sd8388608;

    class biquad_scoreboard;
        typedef struct {
            logic [SW-1:0] sample;
            logic          sat;
        } t_filter_out;

        logic [biquad_pkg::ORDER_W-1:0]       order;
        logic signed [biquad_pkg::COEF_W-1:0] b0, b1, b2, a1, a2;
        logic signed [SW-1:0]                 x_hist [2];
        logic signed [SW-1:0]                 y_hist [2];
        t_filter_out                          expected_outputs [$];
        int                                   errors;

        function new();
            order = biquad_pkg::ORDER_FEED;
            b0 = 32'sh1000_0000;
            b1 = '0;
            b2 = '0;
            a1 = '0;
            a2 = '0;
            x_hist[0] = '0;
            x_hist[1] = '0;
            y_hist[0] = '0;
            y_hist[1] = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [biquad_pkg::CFG_IDX_W-1:0] idx,
                              logic [biquad_pkg::COEF_W-1:0] val);
            case (idx)
                biquad_pkg::CFG_ORDER: order = val[biquad_pkg::ORDER_W-1:0];
                biquad_pkg::CFG_B0:    b0 = val;
                biquad_pkg::CFG_B1:    b1 = val;
                biquad_pkg::CFG_B2:    b2 = val;
                biquad_pkg::CFG_A1:    a1 = val;
                biquad_pkg::CFG_A2:    a2 = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        // Computes the filter response to one accepted transfer.
        function void note_sample(logic mode, logic [SW-1:0] raw);
            t_filter_out r;
            longint xs, acc, q;
            logic signed [SW-1:0] x;
            x = raw;
            xs = x;
            r.sat = 1'b0;
            if (mode == biquad_pkg::MODE_CLEAR) begin
                x_hist[0] = '0;
                x_hist[1] = '0;
                y_hist[0] = '0;
                y_hist[1] = '0;
                r.sample = '0;
            end else if (order != biquad_pkg::ORDER_FIRST
                         && order != biquad_pkg::ORDER_SECOND) begin
                r.sample = raw;
            end else begin
                acc = longint'(b0) * xs + longint'(b1) * longint'(x_hist[0])
                    - longint'(a1) * longint'(y_hist[0]);
                if (order == biquad_pkg::ORDER_SECOND) begin
                    acc = acc + longint'(b2) * longint'(x_hist[1])
                        - longint'(a2) * longint'(y_hist[1]);
                end
                q = (acc + (longint'(1) <<< (biquad_pkg::COEF_FRAC_BITS_DEF - 1)))
                    >>> biquad_pkg::COEF_FRAC_BITS_DEF;
                if (q > SMAX) begin
                    q = SMAX;
                    r.sat = 1'b1;
                end else if (q < SMIN) begin
                    q = SMIN;
                    r.sat = 1'b1;
                end
                if (order == biquad_pkg::ORDER_SECOND) begin
                    x_hist[1] = x_hist[0];
                    y_hist[1] = y_hist[0];
                end
                x_hist[0] = x;
                y_hist[0] = q[SW-1:0];
                r.sample = q[SW-1:0];
            end
            expected_outputs.push_back(r);
        endfunction

        function void check_output(logic [SW-1:0] sample, logic sat);
            t_filter_out e;
            if (expected_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected output transfer, sample %0d sat %0b",
                         $time, $signed(sample), sat);
                return;
            end
            e = expected_outputs.pop_front();
            if (sample !== e.sample) begin
                errors++;
                $display("%0t: sample_out expected %0d actual %0d",
                         $time, $signed(e.sample), $signed(sample));
            end
            if (sat !== e.sat) begin
                errors++;
                $display("%0t: saturated expected %0b actual %0b", $time, e.sat, sat);
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic [biquad_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [biquad_pkg::COEF_W-1:0]    i_cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [TW-1:0]                    s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [TW-1:0]                    m_axis_tdata;
    logic                             m_axis_tuser;

    biquad_scoreboard sb;
    bit               idle_en;
    bit               hold_req;
    int               hold_cnt;
    int               cycles;

    biquad_iir_filter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Output side: checks each result transfer and decides the next tready.
    initial begin
        m_axis_tready <= 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && sb != null && m_axis_tvalid && m_axis_tready)
                sb.check_output(m_axis_tdata, m_axis_tuser);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 300;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(idle_en && $urandom_range(99) < 36);
            end
        end
    end

    task automatic send_item(input logic mode, input logic [SW-1:0] sample);
        while (idle_en && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(mode, sample);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [biquad_pkg::CFG_IDX_W-1:0] idx,
                           input logic [biquad_pkg::COEF_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_setting(input logic [biquad_pkg::ORDER_W-1:0] ord,
                                input logic [biquad_pkg::COEF_W-1:0] c0,
                                input logic [biquad_pkg::COEF_W-1:0] c1,
                                input logic [biquad_pkg::COEF_W-1:0] c2,
                                input logic [biquad_pkg::COEF_W-1:0] d1,
                                input logic [biquad_pkg::COEF_W-1:0] d2,
                                input bit spare);
        put_reg(biquad_pkg::CFG_ORDER, {30'd0, ord});
        put_reg(biquad_pkg::CFG_B0, c0);
        put_reg(biquad_pkg::CFG_B1, c1);
        put_reg(biquad_pkg::CFG_B2, c2);
        put_reg(biquad_pkg::CFG_A1, d1);
        put_reg(biquad_pkg::CFG_A2, d2);
        if (spare) begin
            put_reg(CFG_UNUSED_LO, $urandom());
            put_reg(CFG_UNUSED_HI, $urandom());
        end
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [biquad_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h2000_0000) - 32'h1000_0000;
            2: begin
                case ($urandom_range(2))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    default: return 32'h0;
                endcase
            end
            default: return $urandom_range(32'h0800_0000) - 32'h0400_0000;
        endcase
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        int k;
        k = $urandom_range(99);
        if (k < 70)
            return SW'($urandom());
        else if (k < 80)
            return ($urandom_range(1) != 0) ? 24'h7FFFFF : 24'h800000;
        else
            return SW'($urandom_range(2000) - 1000);
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= biquad_pkg::MODE_FILTER;
        idle_en  = 1'b1;
        hold_req = 1'b0;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Values after reset: feed-through with unity gain.
        send_item(biquad_pkg::MODE_FILTER, 24'h7FFFFF);
        send_item(biquad_pkg::MODE_FILTER, 24'h800000);
        send_item(biquad_pkg::MODE_FILTER, 24'h000000);
        send_item(biquad_pkg::MODE_FILTER, 24'hFFFFFF);
        send_item(biquad_pkg::MODE_CLEAR,  24'h5A5A5A);
        send_item(biquad_pkg::MODE_FILTER, 24'h123456);
        drain();

        // The unused order code behaves as feed-through.
        load_setting(2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_item(biquad_pkg::MODE_FILTER, 24'h7FFFFF);
        send_item(biquad_pkg::MODE_FILTER, 24'h800000);
        drain();

        load_setting(biquad_pkg::ORDER_FIRST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                     32'h7FFF_FFFF, 32'h0, 1'b0);
        send_item(biquad_pkg::MODE_FILTER, 24'h7FFFFF);
        send_item(biquad_pkg::MODE_FILTER, 24'h800000);
        send_item(biquad_pkg::MODE_FILTER, 24'h7FFFFF);
        send_item(biquad_pkg::MODE_CLEAR,  24'h7FFFFF);
        send_item(biquad_pkg::MODE_FILTER, 24'h800000);
        drain();

        // Writes to the spare register indexes must be ignored.
        load_setting(biquad_pkg::ORDER_SECOND, 32'h1000_0000, 32'hF800_0000, 32'h0400_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_item(biquad_pkg::MODE_FILTER, 24'h7FFFFF);
        send_item(biquad_pkg::MODE_FILTER, 24'h000001);
        send_item(biquad_pkg::MODE_FILTER, 24'hFFFFFF);
        send_item(biquad_pkg::MODE_FILTER, 24'h800000);
        send_item(biquad_pkg::MODE_FILTER, 24'h000000);
        send_item(biquad_pkg::MODE_CLEAR,  24'h000064);
        send_item(biquad_pkg::MODE_FILTER, 24'h000064);
        drain();

        // A gain of one half puts the rounding on exact ties.
        load_setting(biquad_pkg::ORDER_FIRST, 32'h0800_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                     1'b0);
        send_item(biquad_pkg::MODE_FILTER, 24'h000001);
        send_item(biquad_pkg::MODE_FILTER, 24'hFFFFFF);
        send_item(biquad_pkg::MODE_FILTER, 24'h000003);
        send_item(biquad_pkg::MODE_FILTER, 24'hFFFFFD);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            load_setting(biquad_pkg::ORDER_W'($urandom_range(3)), pick_coef(), pick_coef(),
                         pick_coef(), pick_coef(), pick_coef(), $urandom_range(3) == 0);
            idle_en = (ph != 2);
            if (ph == 5)
                hold_req = 1'b1;
            for (int n = 0; n < 138; n++)
                send_item(($urandom_range(99) < 4) ? biquad_pkg::MODE_CLEAR
                                                   : biquad_pkg::MODE_FILTER,
                          pick_sample());
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.errors++;
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
